// ===== rtl/tkmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkmc_pkg
// Types, constants and match functions shared by the transmit-key message
// classifier: per-message scan state, verdict codes, record bytes, JSON
// needles and keyword lists.
// ----------------------------------------------------------------------------
package tkmc_pkg;

    localparam int WIN_LEN       = 11;
    localparam int WORD_MAX      = 8;
    localparam int WORD_IDX_W    = $clog2(WORD_MAX);
    localparam int WORD_LEN_W    = $clog2(WORD_MAX + 2);
    localparam int POS_W         = 3;
    localparam int NUM_NEEDLES   = 6;
    localparam int NUM_ON_WORDS  = 8;
    localparam int NUM_OFF_WORDS = 7;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] verdict_t;
    typedef logic [8*WIN_LEN-1:0]  needle_t;
    typedef logic [8*WORD_MAX-1:0] keyword_t;

    localparam verdict_t VERDICT_UNKNOWN = 2'd0;
    localparam verdict_t VERDICT_ON      = 2'd1;
    localparam verdict_t VERDICT_OFF     = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST      = 3'd7;
    localparam logic [POS_W-1:0] POS_RECORD_OK = 3'd6;
    localparam logic [POS_W-1:0] POS_STX       = 3'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 3'd2;
    localparam logic [POS_W-1:0] POS_KIND      = 3'd3;
    localparam logic [POS_W-1:0] POS_O         = 3'd4;
    localparam logic [POS_W-1:0] POS_T         = 3'd5;

    localparam byte_t REC_STX    = 8'h02;
    localparam byte_t REC_LEN_HI = 8'h00;
    localparam byte_t REC_LEN_LO = 8'h03;
    localparam byte_t REC_START  = "S";
    localparam byte_t REC_END    = "E";
    localparam byte_t REC_O      = "O";
    localparam byte_t REC_T      = "T";
    localparam byte_t OPEN_BRACE = "{";
    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_TAB   = 8'h09;
    localparam byte_t CHAR_CR    = 8'h0D;
    localparam byte_t LOWER_A    = "a";
    localparam byte_t LOWER_Z    = "z";
    localparam byte_t CASE_DELTA = 8'd32;

    localparam needle_t ON_NEEDLES [NUM_NEEDLES] = '{
        "\"ptt\":true", "\"tx\":true", "\"key\":true",
        "\"ptt\":1", "\"tx\":1", "\"key\":1"
    };
    localparam int ON_NEEDLE_LEN [NUM_NEEDLES] = '{10, 9, 10, 7, 6, 7};

    localparam needle_t OFF_NEEDLES [NUM_NEEDLES] = '{
        "\"ptt\":false", "\"tx\":false", "\"key\":false",
        "\"ptt\":0", "\"tx\":0", "\"key\":0"
    };
    localparam int OFF_NEEDLE_LEN [NUM_NEEDLES] = '{11, 10, 11, 7, 6, 7};

    localparam keyword_t ON_WORDS [NUM_ON_WORDS] = '{
        "1", "ON", "TX", "PTT", "PTT_ON", "KEYDOWN", {"KEY_", "DOWN"}, "SOT"
    };
    localparam int ON_WORD_LEN [NUM_ON_WORDS] = '{1, 2, 2, 3, 6, 7, 8, 3};

    localparam keyword_t OFF_WORDS [NUM_OFF_WORDS] = '{
        "0", "OFF", "RX", "PTT_OFF", "KEYUP", "KEY_UP", "EOT"
    };
    localparam int OFF_WORD_LEN [NUM_OFF_WORDS] = '{1, 3, 2, 7, 5, 6, 3};

    typedef struct packed {
        logic [POS_W-1:0]             byte_position;
        logic                         record_still_matching;
        logic                         record_is_start;
        logic                         content_seen;
        logic                         brace_mode;
        byte_t [WIN_LEN-1:0]          recent_bytes;
        logic                         found_true_key;
        logic                         found_false_key;
        byte_t [WORD_MAX-1:0]         word_buffer;
        logic [WORD_LEN_W-1:0]        word_length;
        logic                         space_after_word;
        logic                         word_spoiled;
    } tkmc_state_t;

    function automatic tkmc_state_t clear_state();
        tkmc_state_t s;
        s = '0;
        s.record_still_matching = 1'b1;
        return s;
    endfunction

    // newest byte at index 0, needle right-justified (last char in bits 7:0)
    function automatic logic window_ends(input byte_t [WIN_LEN-1:0] win,
                                         input needle_t needle, input int len);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < WIN_LEN; k++) begin
            if (k < len && win[k] != needle[8*k +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic word_is(input byte_t [WORD_MAX-1:0] buffer,
                                     input logic [WORD_LEN_W-1:0] wlen,
                                     input keyword_t kw, input int len);
        logic     hit;
        keyword_t aligned;
        aligned = kw << (8 * (WORD_MAX - len));
        hit = (wlen == WORD_LEN_W'(len));
        for (int i = 0; i < WORD_MAX; i++) begin
            if (i < len && buffer[i] != aligned[8*(WORD_MAX-1-i) +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tkmc_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkmc_update
// Next-state logic for one message byte: record header tracking, sliding
// window needle search, and trimmed upper-case word capture.
// ----------------------------------------------------------------------------
module tkmc_update (
    input  wire tkmc_pkg::tkmc_state_t state_cur,
    input  wire tkmc_pkg::byte_t       msg_byte,
    output tkmc_pkg::tkmc_state_t      state_next
);
    import tkmc_pkg::*;

    logic  is_ws;
    logic  rec_ok;
    byte_t upper_byte;

    assign is_ws = (msg_byte == CHAR_SPACE) ||
                   (msg_byte >= CHAR_TAB && msg_byte <= CHAR_CR);
    assign upper_byte = (msg_byte >= LOWER_A && msg_byte <= LOWER_Z) ?
                        (msg_byte - CASE_DELTA) : msg_byte;

    always_comb begin
        state_next = state_cur;
        rec_ok     = 1'b1;

        if (state_cur.record_still_matching) begin
            unique case (state_cur.byte_position)
                POS_STX:    rec_ok = (msg_byte == REC_STX);
                POS_LEN_HI: rec_ok = (msg_byte == REC_LEN_HI);
                POS_LEN_LO: rec_ok = (msg_byte == REC_LEN_LO);
                POS_KIND: begin
                    if (msg_byte == REC_START) begin
                        state_next.record_is_start = 1'b1;
                    end else if (msg_byte == REC_END) begin
                        state_next.record_is_start = 1'b0;
                    end else begin
                        rec_ok = 1'b0;
                    end
                end
                POS_O:      rec_ok = (msg_byte == REC_O);
                POS_T:      rec_ok = (msg_byte == REC_T);
                default:    rec_ok = 1'b1;
            endcase
            if (!rec_ok) begin
                state_next.record_still_matching = 1'b0;
            end
        end
        if (state_cur.byte_position < POS_LAST) begin
            state_next.byte_position = state_cur.byte_position + 1'b1;
        end

        // shift window, newest byte at index 0
        state_next.recent_bytes = {state_cur.recent_bytes[WIN_LEN-2:0], msg_byte};
        for (int i = 0; i < NUM_NEEDLES; i++) begin
            if (window_ends(state_next.recent_bytes, ON_NEEDLES[i], ON_NEEDLE_LEN[i])) begin
                state_next.found_true_key = 1'b1;
            end
            if (window_ends(state_next.recent_bytes, OFF_NEEDLES[i],
                            OFF_NEEDLE_LEN[i])) begin
                state_next.found_false_key = 1'b1;
            end
        end

        if (!is_ws) begin
            if (!state_cur.content_seen) begin
                state_next.content_seen = 1'b1;
                state_next.brace_mode   = (msg_byte == OPEN_BRACE);
            end else if (state_cur.space_after_word) begin
                state_next.word_spoiled = 1'b1;
            end
            if (state_cur.word_length < WORD_LEN_W'(WORD_MAX)) begin
                state_next.word_buffer[state_cur.word_length[WORD_IDX_W-1:0]] = upper_byte;
            end
            if (state_cur.word_length < WORD_LEN_W'(WORD_MAX + 1)) begin
                state_next.word_length = state_cur.word_length + 1'b1;
            end
            state_next.space_after_word = 1'b0;
        end else if (state_cur.content_seen) begin
            state_next.space_after_word = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tkmc_decide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkmc_decide
// Verdict from the scan state after the last byte: record first, then
// brace-mode key flags, then exact keyword match.
// ----------------------------------------------------------------------------
module tkmc_decide (
    input  wire tkmc_pkg::tkmc_state_t state_in,
    output tkmc_pkg::verdict_t         verdict
);
    import tkmc_pkg::*;

    logic on_hit;
    logic off_hit;

    always_comb begin
        on_hit  = 1'b0;
        off_hit = 1'b0;
        for (int i = 0; i < NUM_ON_WORDS; i++) begin
            if (word_is(state_in.word_buffer, state_in.word_length,
                        ON_WORDS[i], ON_WORD_LEN[i])) begin
                on_hit = 1'b1;
            end
        end
        for (int i = 0; i < NUM_OFF_WORDS; i++) begin
            if (word_is(state_in.word_buffer, state_in.word_length,
                        OFF_WORDS[i], OFF_WORD_LEN[i])) begin
                off_hit = 1'b1;
            end
        end
    end

    always_comb begin
        if (state_in.record_still_matching && state_in.byte_position >= POS_RECORD_OK) begin
            verdict = state_in.record_is_start ? VERDICT_ON : VERDICT_OFF;
        end else if (!state_in.content_seen) begin
            verdict = VERDICT_UNKNOWN;
        end else if (state_in.brace_mode) begin
            if (state_in.found_true_key) begin
                verdict = VERDICT_ON;
            end else if (state_in.found_false_key) begin
                verdict = VERDICT_OFF;
            end else begin
                verdict = VERDICT_UNKNOWN;
            end
        end else if (state_in.word_spoiled ||
                     state_in.word_length > WORD_LEN_W'(WORD_MAX)) begin
            verdict = VERDICT_UNKNOWN;
        end else if (on_hit) begin
            verdict = VERDICT_ON;
        end else if (off_hit) begin
            verdict = VERDICT_OFF;
        end else begin
            verdict = VERDICT_UNKNOWN;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tx_key_message_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tx_key_message_classifier_core
// The verdict is registered and is valid in the cycle after the final byte's transfer.
// Throughput: one byte per cycle while s_ready is high; the state register
// updates on every transfer, the verdict register on a final byte's transfer.
// A byte is taken while the verdict register is empty or being drained.
// Reset clears the scan state to an empty message and empties the output.
// ----------------------------------------------------------------------------
module tx_key_message_classifier_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  tkmc_pkg::byte_t   s_msg_byte,
    input  wire                     s_final_byte,
    output logic                    m_valid,
    input  wire                     m_ready,
    output tkmc_pkg::verdict_t      m_verdict
);
    import tkmc_pkg::*;

    tkmc_state_t state_reg;
    tkmc_state_t state_next;
    logic        m_valid_reg;
    verdict_t    m_verdict_reg;
    verdict_t    verdict_next;
    logic        s_xfer;

    tkmc_update u_update (
        .state_cur  (state_reg),
        .msg_byte   (s_msg_byte),
        .state_next (state_next)
    );

    tkmc_decide u_decide (
        .state_in (state_next),
        .verdict  (verdict_next)
    );

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clear_state();
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg <= s_final_byte ? clear_state() : state_next;
            end
            if (s_xfer && s_final_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && s_final_byte) begin
            m_verdict_reg <= verdict_next;
        end
    end

endmodule
`default_nettype wire
